// ===== design/lsc_pkg.sv =====
`default_nettype none

package lsc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_MIN_BRIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BRIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BUTTON_CNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PORT_CNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_RGB    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_RGB   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_OK_RGB      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_RGB   = 3'd7;

   localparam logic [14:0] LUMA_FLOOR = 15'd100;

   typedef struct packed {
      logic [7:0]  min_bright;
      logic [7:0]  max_bright;
      logic [3:0]  button_led_count;
      logic [3:0]  port_led_count;
      logic [23:0] idle_rgb;
      logic [23:0] press_rgb;
      logic [23:0] ok_rgb;
      logic [23:0] fault_rgb;
   } lsc_cfg_type;

   // one pixel leaving the sequencer
   typedef struct packed {
      logic [3:0]  led_index;
      logic [23:0] rgb;
      logic [7:0]  ambient;
      logic        last;
   } lsc_pix_type;

   // per-channel fraction: num / den, channel 2 is red
   typedef struct packed {
      logic [3:0]       led_index;
      logic             last;
      logic [2:0][23:0] num;
      logic [15:0]      den;
   } lsc_frac_type;

   typedef struct packed {
      logic [3:0]      led_index;
      logic            last;
      logic [2:0][7:0] chan;
   } lsc_out_type;

endpackage

`default_nettype wire

// ===== design/lsc_seq.sv =====
`default_nettype none

module lsc_seq #(
   parameter int MAX_BUTTON_LEDS = 8,
   parameter int MAX_PORT_LEDS   = 8
) (
   input  wire                 clock,
   input  wire                 reset,
   input  lsc_pkg::lsc_cfg_type cfg,
   input  wire                 adv,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_ambient,
   input  wire  [7:0]          req_button_bits,
   input  wire  [7:0]          req_port_ok_bits,
   output logic                pix_valid,
   output lsc_pkg::lsc_pix_type pix
);
   import lsc_pkg::*;

   localparam int BW = (MAX_BUTTON_LEDS > 1) ? $clog2(MAX_BUTTON_LEDS) : 1;
   localparam int PW = (MAX_PORT_LEDS > 1) ? $clog2(MAX_PORT_LEDS) : 1;

   logic                       busy_ff, busy_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic [7:0]                 amb_ff;
   logic [MAX_BUTTON_LEDS-1:0] btn_ff;
   logic [MAX_PORT_LEDS-1:0]   port_ff;
   logic                       pix_valid_ff;
   lsc_pix_type                pix_ff, pix_in;

   logic [3:0]  nb, np, bidx, pidx;
   logic [4:0]  total;
   logic        final_beat, take, accept, is_btn, btn_bit, port_bit;
   logic [23:0] color;

   always_comb begin
      nb = (cfg.button_led_count > 4'(MAX_BUTTON_LEDS)) ? 4'(MAX_BUTTON_LEDS)
                                                        : cfg.button_led_count;
      np = (cfg.port_led_count > 4'(MAX_PORT_LEDS)) ? 4'(MAX_PORT_LEDS)
                                                    : cfg.port_led_count;
      total      = {1'b0, nb} + {1'b0, np};
      final_beat = busy_ff && ({1'b0, cnt_ff} + 5'd1 == total);
      take       = adv && (!busy_ff || final_beat);
      accept     = take && req_valid;

      is_btn   = cnt_ff < nb;
      bidx     = nb - 4'd1 - cnt_ff;
      pidx     = cnt_ff - nb;
      btn_bit  = btn_ff[bidx[BW-1:0]];
      port_bit = port_ff[pidx[PW-1:0]];
      if (is_btn) begin
         color = btn_bit ? cfg.idle_rgb : cfg.press_rgb;
      end else begin
         color = port_bit ? cfg.ok_rgb : cfg.fault_rgb;
      end

      pix_in.led_index = cnt_ff;
      pix_in.rgb       = color;
      pix_in.ambient   = amb_ff;
      pix_in.last      = final_beat;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = (total != 5'd0);
         cnt_in  = 4'd0;
      end else if (adv && busy_ff) begin
         busy_in = !final_beat;
         cnt_in  = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= 4'd0;
         pix_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         if (adv) begin
            pix_valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         amb_ff  <= req_ambient;
         btn_ff  <= req_button_bits[MAX_BUTTON_LEDS-1:0];
         port_ff <= req_port_ok_bits[MAX_PORT_LEDS-1:0];
      end
      if (adv) begin
         pix_ff <= pix_in;
      end
   end

   assign req_stall = !take;
   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (total != 5'd0) |=> busy_ff && (cnt_ff == 4'd0))
      else $error("render did not start at pixel zero");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !adv |=> busy_ff && $stable(cnt_ff))
      else $error("sequencer moved while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !busy_ff || final_beat)
      else $error("request taken mid render");

endmodule

`default_nettype wire

// ===== design/lsc_scale.sv =====
`default_nettype none

module lsc_scale (
   input  wire                   clock,
   input  wire                   reset,
   input  lsc_pkg::lsc_cfg_type  cfg,
   input  wire                   adv,
   input  wire                   pix_valid,
   input  lsc_pkg::lsc_pix_type  pix,
   output logic                  frac_valid,
   output lsc_pkg::lsc_frac_type frac
);
   import lsc_pkg::*;

   // stage 2: brightness mix
   logic             v2_ff;
   logic [3:0]       idx2_ff;
   logic             last2_ff;
   logic [23:0]      rgb2_ff;
   logic [15:0]      mix2_ff, mix2_in;
   // stage 3: brightness code, luma
   logic             v3_ff;
   logic [3:0]       idx3_ff;
   logic             last3_ff;
   logic [23:0]      rgb3_ff;
   logic [7:0]       bright3_ff, bright3_in;
   logic [14:0]      luma3_ff, luma3_in;
   // stage 4: channel times brightness
   logic             v4_ff;
   logic [3:0]       idx4_ff;
   logic             last4_ff;
   logic [2:0][15:0] prod4_ff, prod4_in;
   logic [14:0]      luma4_ff;
   // stage 5: numerator and denominator
   logic             v5_ff;
   lsc_frac_type     frac5_ff, frac5_in;

   logic [15:0] div_t;
   logic [14:0] luma_raw;
   logic [2:0][23:0] p24;

   always_comb begin
      mix2_in = 16'(cfg.min_bright) * 16'(8'd255 - pix.ambient)
              + 16'(cfg.max_bright) * 16'(pix.ambient) + 16'd127;

      // floor(x / 255) for x below 65280
      div_t      = mix2_ff + 16'd1 + 16'(mix2_ff[15:8]);
      bright3_in = div_t[15:8];
      luma_raw   = 15'(rgb2_ff[23:16]) * 15'd30 + 15'(rgb2_ff[15:8]) * 15'd59
                 + 15'(rgb2_ff[7:0]) * 15'd11;
      luma3_in   = (luma_raw < LUMA_FLOOR) ? LUMA_FLOOR : luma_raw;

      for (int ch = 0; ch < 3; ch++) begin
         prod4_in[ch] = 16'(rgb3_ff[ch*8 +: 8]) * 16'(bright3_ff);
      end

      for (int ch = 0; ch < 3; ch++) begin
         p24[ch] = 24'(prod4_ff[ch]);
         // 200 = 128 + 64 + 8
         frac5_in.num[ch] = (p24[ch] << 7) + (p24[ch] << 6) + (p24[ch] << 3)
                          + 24'(luma4_ff);
      end
      frac5_in.den       = {1'b0, luma4_ff} << 1;
      frac5_in.led_index = idx4_ff;
      frac5_in.last      = last4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= pix_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx2_ff    <= pix.led_index;
         last2_ff   <= pix.last;
         rgb2_ff    <= pix.rgb;
         mix2_ff    <= mix2_in;
         idx3_ff    <= idx2_ff;
         last3_ff   <= last2_ff;
         rgb3_ff    <= rgb2_ff;
         bright3_ff <= bright3_in;
         luma3_ff   <= luma3_in;
         idx4_ff    <= idx3_ff;
         last4_ff   <= last3_ff;
         prod4_ff   <= prod4_in;
         luma4_ff   <= luma3_ff;
         frac5_ff   <= frac5_in;
      end
   end

   assign frac_valid = v5_ff;
   assign frac       = frac5_ff;

endmodule

`default_nettype wire

// ===== design/lsc_div.sv =====
`default_nettype none

module lsc_div (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   adv,
   input  wire                   frac_valid,
   input  lsc_pkg::lsc_frac_type frac,
   output logic                  out_valid,
   output lsc_pkg::lsc_out_type  out
);
   import lsc_pkg::*;

   // stage 0 checks saturation, stages 1..8 each resolve one quotient bit
   logic [8:0]      vld_ff;
   logic [2:0][23:0] rem_ff [0:7];
   logic [15:0]     den_ff [0:7];
   logic [2:0]      sat_ff [0:8];
   logic [2:0][7:0] quo_ff [0:8];
   logic [3:0]      idx_ff [0:8];
   logic [8:0]      last_ff;

   logic [2:0] sat_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sat_in[ch] = frac.num[ch] >= {frac.den, 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= frac_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= frac.num;
         den_ff[0]  <= frac.den;
         sat_ff[0]  <= sat_in;
         quo_ff[0]  <= '0;
         idx_ff[0]  <= frac.led_index;
         last_ff[0] <= frac.last;
      end
   end

   for (genvar s = 0; s < 8; s++) begin : g_step
      localparam int K = 7 - s;
      logic [24:0]      dsh;
      logic [2:0][24:0] diff;
      logic [2:0]       ge;
      logic [2:0][7:0]  quo_next;

      always_comb begin
         dsh = 25'(den_ff[s]) << K;
         for (int ch = 0; ch < 3; ch++) begin
            diff[ch]     = {1'b0, rem_ff[s][ch]} - dsh;
            ge[ch]       = !diff[ch][24];
            quo_next[ch] = {quo_ff[s][ch][6:0], ge[ch]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sat_ff[s+1]  <= sat_ff[s];
            quo_ff[s+1]  <= quo_next;
            idx_ff[s+1]  <= idx_ff[s];
            last_ff[s+1] <= last_ff[s];
         end
      end

      if (s < 7) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               den_ff[s+1] <= den_ff[s];
               for (int ch = 0; ch < 3; ch++) begin
                  rem_ff[s+1][ch] <= ge[ch] ? diff[ch][23:0] : rem_ff[s][ch];
               end
            end
         end
      end
   end

   always_comb begin
      out.led_index = idx_ff[8];
      out.last      = last_ff[8];
      for (int ch = 0; ch < 3; ch++) begin
         out.chan[ch] = sat_ff[8][ch] ? 8'hFF : quo_ff[8][ch];
      end
   end

   assign out_valid = vld_ff[8];

endmodule

`default_nettype wire

// ===== design/led_status_color_scaler.sv =====
// LED status color scaler.
// Request channel (req_): one beat is one render request carrying the ambient
// level, the active-low button bits and the port ok bits. Response channel
// (rsp_): one beat per LED, button LEDs first, then port LEDs, rsp_last set on
// the final pixel. A render with no LEDs is taken and yields no beats.
// Configuration: csr_write with csr_index/csr_data writes one register in a
// cycle; write only while no render is in flight.
// Flow: a request beat passes the sequencer registers, the scale stages, the
// divide stages and the output register; pixels then follow one per cycle
// while rsp_stall does not hold. The next request is taken in the cycle the
// last pixel of a render leaves the sequencer. The channel divide is an 8-stage
// restoring pipeline, one quotient bit per stage, three channels side by side.
// Reset clears the pipeline and loads the register defaults.
// Stall: while rsp_stall holds a waiting beat, the whole pipeline and the
// sequencer freeze and req_stall is raised; nothing is dropped or repeated.
`default_nettype none

module led_status_color_scaler #(
   parameter int MAX_BUTTON_LEDS = 8,
   parameter int MAX_PORT_LEDS   = 8
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [7:0]                      req_ambient,
   input  wire  [7:0]                      req_button_bits,
   input  wire  [7:0]                      req_port_ok_bits,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [3:0]                      rsp_led_index,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   output logic                            rsp_last,
   input  wire                             csr_write,
   input  wire  [lsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [lsc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lsc_pkg::*;

   lsc_cfg_type  cfg_ff, cfg_in;
   logic         adv;
   logic         pix_valid, frac_valid, div_valid;
   lsc_pix_type  pix;
   lsc_frac_type frac;
   lsc_out_type  div_out;
   logic         rsp_valid_ff;
   lsc_out_type  rsp_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MIN_BRIGHT: cfg_in.min_bright       = csr_data[7:0];
            REG_MAX_BRIGHT: cfg_in.max_bright       = csr_data[7:0];
            REG_BUTTON_CNT: cfg_in.button_led_count = csr_data[3:0];
            REG_PORT_CNT:   cfg_in.port_led_count   = csr_data[3:0];
            REG_IDLE_RGB:   cfg_in.idle_rgb         = csr_data;
            REG_PRESS_RGB:  cfg_in.press_rgb        = csr_data;
            REG_OK_RGB:     cfg_in.ok_rgb           = csr_data;
            REG_FAULT_RGB:  cfg_in.fault_rgb        = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bright       <= 8'd25;
         cfg_ff.max_bright       <= 8'd255;
         cfg_ff.button_led_count <= 4'd4;
         cfg_ff.port_led_count   <= 4'd4;
         cfg_ff.idle_rgb         <= 24'hFFFFFF;
         cfg_ff.press_rgb        <= 24'h0000FF;
         cfg_ff.ok_rgb           <= 24'h00FF00;
         cfg_ff.fault_rgb        <= 24'hFFA500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsc_seq #(
      .MAX_BUTTON_LEDS (MAX_BUTTON_LEDS),
      .MAX_PORT_LEDS   (MAX_PORT_LEDS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .adv              (adv),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ambient      (req_ambient),
      .req_button_bits  (req_button_bits),
      .req_port_ok_bits (req_port_ok_bits),
      .pix_valid        (pix_valid),
      .pix              (pix)
   );

   lsc_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .adv        (adv),
      .pix_valid  (pix_valid),
      .pix        (pix),
      .frac_valid (frac_valid),
      .frac       (frac)
   );

   lsc_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .frac_valid (frac_valid),
      .frac       (frac),
      .out_valid  (div_valid),
      .out        (div_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= div_out;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_ff.led_index;
   assign rsp_red       = rsp_ff.chan[2];
   assign rsp_green     = rsp_ff.chan[1];
   assign rsp_blue      = rsp_ff.chan[0];
   assign rsp_last      = rsp_ff.last;

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pix_valid) && $stable(frac_valid) && $stable(div_valid))
      else $error("pipeline moved during output stall");

   a_req_needs_adv: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> adv)
      else $error("request taken while output blocked");

   a_fault_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == REG_FAULT_RGB) |=> cfg_ff.fault_rgb == $past(csr_data))
      else $error("fault color write lost");

endmodule

`default_nettype wire
